/* src/backslash_escape_decoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// Backslash escape decoder assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define BED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bed_pkg.sv */
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Character codes, decode modes, the command passed from front to back and a hex digit decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

    localparam int MaxRes = 5;
    localparam int CntW   = 3;

    localparam logic [7:0] ChBslash = 8'h5c;
    localparam logic [7:0] ChX      = 8'h78;
    localparam logic [7:0] ChR      = 8'h72;
    localparam logic [7:0] ChN      = 8'h6e;
    localparam logic [7:0] ChT      = 8'h74;
    localparam logic [7:0] CtlCr    = 8'h0d;
    localparam logic [7:0] CtlLf    = 8'h0a;
    localparam logic [7:0] CtlTab   = 8'h09;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESC    = 3'b010,
        MODE_HEX    = 3'b100
    } mode_t;

    // one run of results caused by a single input beat
    typedef struct packed {
        logic [MaxRes-1:0][7:0] bytes;
        logic [CntW-1:0]        cnt;     // 1..MaxRes
        logic                   has;     // 0 only for a bare end marker
        logic                   eot;
    } cmd_t;

    // {valid, nibble} for a strict hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'h00;
        r = 5'b0_0000;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            r = {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

/* src/bed_in_if.sv */
// ----------------------------------------------------------------------------
// Escaped text channel
// Valid/ready stream of encoded characters with an end-of-string flag.
// ----------------------------------------------------------------------------
interface bed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       string_end;

    modport source (output valid, output in_byte, output string_end, input ready);
    modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

/* src/bed_out_if.sv */
// ----------------------------------------------------------------------------
// Decoded text channel
// Valid/ready stream of decoded characters with run and end markers.
// ----------------------------------------------------------------------------
interface bed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;
    logic       run_last;

    modport source (output valid, output out_byte, output has_byte,
                    output end_of_text, output run_last, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input end_of_text, input run_last, output ready);
endinterface

/* src/bed_front.sv */
// ----------------------------------------------------------------------------
// Escape decoder front end
// Tracks escape state and turns each input beat into at most one result run.
// ----------------------------------------------------------------------------
module bed_front
    import bed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    bed_in_if.sink   enc,
    output logic     push_valid,
    input  logic     push_ready,
    output cmd_t     push_cmd
);

    mode_t      mode_reg, mode_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;

    logic [7:0] b;
    logic       judge;
    logic       tail_en;
    logic [7:0] pair_hi, pair_lo;
    logic [4:0] hx_hi, hx_lo;
    cmd_t       cmd;

    assign b = enc.in_byte;

    always_comb
    begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        judge      = 1'b0;
        tail_en    = 1'b0;
        pair_hi    = held0_reg;
        pair_lo    = held1_reg;
        cmd        = '0;
        cmd.has    = 1'b1;

        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_NORMAL;
                case (b)
                    ChBslash: begin cmd.bytes[0] = ChBslash; cmd.cnt = 3'd1; end
                    ChR:      begin cmd.bytes[0] = CtlCr;    cmd.cnt = 3'd1; end
                    ChN:      begin cmd.bytes[0] = CtlLf;    cmd.cnt = 3'd1; end
                    ChT:      begin cmd.bytes[0] = CtlTab;   cmd.cnt = 3'd1; end
                    ChX:
                    begin
                        mode_next = MODE_HEX;
                        cnt_next  = 2'd0;
                    end
                    default:
                    begin
                        cmd.bytes[0] = ChBslash;
                        cmd.bytes[1] = b;
                        cmd.cnt      = 3'd2;
                    end
                endcase
            end
            MODE_HEX:
            begin
                if (!cnt_reg[1])
                begin
                    if (cnt_reg[0])
                        held1_next = b;
                    else
                        held0_next = b;
                    cnt_next = cnt_reg + 2'd1;
                    // pair completes on the final beat: judge it now
                    if (enc.string_end && cnt_reg[0])
                    begin
                        judge   = 1'b1;
                        pair_lo = b;
                    end
                end
                else
                begin
                    judge     = 1'b1;
                    mode_next = MODE_NORMAL;
                    tail_en   = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                tail_en   = 1'b1;
            end
        endcase

        hx_hi = hex_digit(pair_hi);
        hx_lo = hex_digit(pair_lo);

        if (judge)
        begin
            cnt_next = 2'd0;
            if (hx_hi[4] && hx_lo[4])
            begin
                cmd.bytes[0] = {hx_hi[3:0], hx_lo[3:0]};
                cmd.cnt      = 3'd1;
            end
            else
            begin
                cmd.bytes[0] = ChBslash;
                cmd.bytes[1] = ChX;
                cmd.bytes[2] = pair_hi;
                cmd.bytes[3] = pair_lo;
                cmd.cnt      = 3'd4;
            end
        end

        if (tail_en)
        begin
            if (b == ChBslash)
                mode_next = MODE_ESC;
            else
            begin
                cmd.bytes[cmd.cnt] = b;
                cmd.cnt            = cmd.cnt + 3'd1;
            end
        end

        if (enc.string_end)
        begin
            mode_next = MODE_NORMAL;
            cnt_next  = 2'd0;
            cmd.eot   = 1'b1;
            if (cmd.cnt == 3'd0)
            begin
                cmd.cnt = 3'd1;
                cmd.has = 1'b0;
            end
        end
    end

    assign enc.ready  = push_ready;
    assign push_valid = enc.valid && (cmd.cnt != 3'd0);
    assign push_cmd   = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 2'd0;
        end
        else if (enc.valid && push_ready)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enc.valid && push_ready)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

/* src/bed_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Escape decoder command queue
// Small register FIFO between front end and back end.
// ----------------------------------------------------------------------------
module bed_cmd_fifo
    import bed_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0]   LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CountW-1:0] Full    = CountW'(DEPTH);

    cmd_t              mem_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CountW-1:0] count_reg;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != Full);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* src/bed_back.sv */
// ----------------------------------------------------------------------------
// Escape decoder back end
// Plays out each queued run one result beat per cycle, while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module bed_back
    import bed_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     head_valid,
    output logic     head_pop,
    input  cmd_t     head_cmd,
    bed_out_if.source dec
);

    logic [CntW-1:0] idx_reg;
    logic            out_valid_reg;
    logic [7:0]      out_byte_reg;
    logic            has_byte_reg, eot_reg, run_last_reg;
    logic            load, is_last;

    assign load     = head_valid && (!out_valid_reg || dec.ready);
    assign is_last  = (idx_reg == head_cmd.cnt - 3'd1);
    assign head_pop = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= is_last ? '0 : idx_reg + 3'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (dec.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head_cmd.bytes[idx_reg];
            has_byte_reg <= head_cmd.has;
            eot_reg      <= head_cmd.eot && is_last;
            run_last_reg <= is_last;
        end
    end

    assign dec.valid       = out_valid_reg;
    assign dec.out_byte    = out_byte_reg;
    assign dec.has_byte    = has_byte_reg;
    assign dec.end_of_text = eot_reg;
    assign dec.run_last    = run_last_reg;

endmodule

/* src/backslash_escape_decoder_unit.sv */
// An input beat's run reaches the output through the queue write, then the
// output register.
// One input beat per cycle while the queue has room; the back end drains one result
// per cycle while the output is ready, so a run of n results takes n output beats.
// The command queue (FIFO_DEPTH runs) absorbs short bursts; once it is full, input stalls.
// Reset (rst_n low, async): normal mode, no held hex characters, queue and output empty.
// ----------------------------------------------------------------------------
// Backslash escape decoder top level
// Front end classifies escaped characters, back end plays out decoded bytes.
// ----------------------------------------------------------------------------
`include "backslash_escape_decoder_unit_macros.svh"

module backslash_escape_decoder_unit
    import bed_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    bed_in_if.sink    enc,
    bed_out_if.source dec
);

    logic push_valid, push_ready;
    cmd_t push_cmd;
    logic head_valid, head_pop;
    cmd_t head_cmd;

    logic push_fire, run_len_ok;
    logic bare_beat, bare_ok, eot_beat, out_stall;

    bed_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enc        (enc),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    bed_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop),
        .pop_cmd    (head_cmd)
    );

    bed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_cmd   (head_cmd),
        .dec        (dec)
    );

    assign push_fire  = push_valid && push_ready;
    assign run_len_ok = (push_cmd.cnt != 3'd0) && (push_cmd.cnt <= 3'(MaxRes));
    assign bare_beat  = dec.valid && !dec.has_byte;
    assign bare_ok    = dec.end_of_text && dec.run_last;
    assign eot_beat   = dec.valid && dec.end_of_text;
    assign out_stall  = dec.valid && !dec.ready;

    // queued runs are never empty and never longer than the result limit
    `BED_ASSERT_NOW(a_run_len, push_fire, run_len_ok, "bad run length queued")
    // a bare marker only closes a string
    `BED_ASSERT_NOW(a_bare_end, bare_beat, bare_ok, "bare result not at string end")
    // string end is always the last beat of its run
    `BED_ASSERT_NOW(a_eot_last, eot_beat, dec.run_last, "end of text inside a run")
    // a stalled output beat stays valid and unchanged
    `BED_ASSERT_NEXT(a_hold, out_stall, dec.valid && $stable(dec.out_byte), "stall lost beat")

endmodule
